FILE: sv/c2p_pkg.sv
// ----------------------------------------------------------------------------
// c2p_pkg: shared types and constants
// Word formats handed between the cells of the conversion chain, the CORDIC
// arctangent table and the fixed widths of the block.
// ----------------------------------------------------------------------------
package c2p_pkg;

   // Field widths
   localparam int DW = 32;              // input and output fields
   localparam int WW = 64;              // wide datapath (squares, products)
   localparam int ZW = 34;              // angle accumulator
   localparam int MRW = 17;             // min_range register

   // Chain lengths
   localparam int ROOT_CELLS = 32;      // one result bit of the square root each
   localparam int DIV_CELLS = 33;       // one quotient bit each
   localparam int PRE_SHIFT = 29;       // 61 - DW, headroom for the CORDIC gain

   // Register map
   localparam logic REG_MIN_RANGE = 1'b0;
   localparam logic [MRW-1:0] MIN_RANGE_RESET = 17'd66;

   // Angles in Q3.29 radians
   localparam logic [DW-1:0] PI_Q29 = 32'd1686629713;

   localparam logic [DW-1:0] ATAN_TAB [ROOT_CELLS] = '{
      32'd421657428, 32'd248918915, 32'd131521918, 32'd66762579,
      32'd33510843,  32'd16771758,  32'd8387925,   32'd4194219,
      32'd2097141,   32'd1048575,   32'd524288,    32'd262144,
      32'd131072,    32'd65536,     32'd32768,     32'd16384,
      32'd8192,      32'd4096,      32'd2048,      32'd1024,
      32'd512,       32'd256,       32'd128,       32'd64,
      32'd32,        32'd16,        32'd8,         32'd4,
      32'd2,         32'd1,         32'd0,         32'd0
   };

   // Word moving through the root / CORDIC cells
   typedef struct packed {
      logic [WW-1:0]        rad;    // square-root remainder
      logic [WW-1:0]        root;   // square-root partial result
      logic signed [WW-1:0] cx;     // CORDIC x
      logic signed [WW-1:0] cy;     // CORDIC y
      logic signed [ZW-1:0] cz;     // CORDIC angle
      logic                 zero;   // both coordinates zero
      logic [WW-1:0]        dot;    // |px*vx + py*vy|
      logic                 neg;    // sign of the dot product
   } root_word_type;

   // Word moving through the divider cells
   typedef struct packed {
      logic [DW:0]          rem;    // partial remainder
      logic [DW:0]          quo;    // quotient bits
      logic [WW-1:0]        dvd;    // dividend
      logic [DW-1:0]        dvs;    // divisor (clamped range)
      logic                 ovf;    // quotient beyond 33 bits
      logic                 neg;
      logic [DW-1:0]        rng;
      logic signed [DW-1:0] brg;
   } div_word_type;

   // Result word
   typedef struct packed {
      logic [DW-1:0]        rng;
      logic signed [DW-1:0] brg;
      logic signed [DW-1:0] rate;
      logic                 sat;
   } result_type;

endpackage

FILE: sv/c2p_front.sv
// ----------------------------------------------------------------------------
// c2p_front: input stages
// Squares and velocity products, then the radicand, the magnitude and sign of
// the dot product and the start vector of the CORDIC.
// ----------------------------------------------------------------------------
module c2p_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic signed [31:0]     pos_x,
   input  logic signed [31:0]     pos_y,
   input  logic signed [31:0]     vel_x,
   input  logic signed [31:0]     vel_y,
   output logic                   out_valid,
   output c2p_pkg::root_word_type out_word
);
   import c2p_pkg::*;

   logic                 s1_valid_ff;
   logic [WW-1:0]        sqx_ff, sqx_in;
   logic [WW-1:0]        sqy_ff, sqy_in;
   logic signed [WW-1:0] p1_ff, p1_in;
   logic signed [WW-1:0] p2_ff, p2_in;
   logic signed [WW-1:0] cx_ff, cx_in;
   logic signed [WW-1:0] cy_ff, cy_in;
   logic signed [ZW-1:0] cz_ff, cz_in;
   logic                 zero_ff, zero_in;
   logic [DW-1:0]        mag_x, mag_y;
   logic signed [WW-1:0] ext_x, ext_y;

   logic                 s2_valid_ff;
   root_word_type        word_ff, word_in;
   logic [WW-1:0]        m1, m2;

   // stage 1: magnitudes squared, products, CORDIC start vector
   always_comb begin
      mag_x = pos_x[DW-1] ? DW'(-pos_x) : DW'(pos_x);
      mag_y = pos_y[DW-1] ? DW'(-pos_y) : DW'(pos_y);
      sqx_in = WW'(mag_x) * WW'(mag_x);
      sqy_in = WW'(mag_y) * WW'(mag_y);
      p1_in = pos_x * vel_x;
      p2_in = pos_y * vel_y;
      ext_x = $signed({{(WW-DW-PRE_SHIFT){pos_x[DW-1]}}, pos_x, {PRE_SHIFT{1'b0}}});
      ext_y = $signed({{(WW-DW-PRE_SHIFT){pos_y[DW-1]}}, pos_y, {PRE_SHIFT{1'b0}}});
      zero_in = (pos_x == '0) && (pos_y == '0);
      // negative x: turn the vector by pi
      if (pos_x[DW-1]) begin
         cx_in = -ext_x;
         cy_in = -ext_y;
         cz_in = pos_y[DW-1] ? -$signed({2'b00, PI_Q29}) : $signed({2'b00, PI_Q29});
      end else begin
         cx_in = ext_x;
         cy_in = ext_y;
         cz_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
      if (en) begin
         sqx_ff  <= sqx_in;
         sqy_ff  <= sqy_in;
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         cz_ff   <= cz_in;
         zero_ff <= zero_in;
      end
   end

   // stage 2: radicand and signed-magnitude dot product
   always_comb begin
      m1 = p1_ff[WW-1] ? WW'(-p1_ff) : WW'(p1_ff);
      m2 = p2_ff[WW-1] ? WW'(-p2_ff) : WW'(p2_ff);
      word_in.rad  = sqx_ff + sqy_ff;
      word_in.root = '0;
      word_in.cx   = cx_ff;
      word_in.cy   = cy_ff;
      word_in.cz   = cz_ff;
      word_in.zero = zero_ff;
      if (p1_ff[WW-1] == p2_ff[WW-1]) begin
         word_in.dot = m1 + m2;
         word_in.neg = p1_ff[WW-1];
      end else if (m1 >= m2) begin
         word_in.dot = m1 - m2;
         word_in.neg = p1_ff[WW-1];
      end else begin
         word_in.dot = m2 - m1;
         word_in.neg = p2_ff[WW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_word  = word_ff;

endmodule

FILE: sv/c2p_root_cell.sv
// ----------------------------------------------------------------------------
// c2p_root_cell: one cell of the root / CORDIC chain
// Settles one bit of the square root and, when enabled, does one vectoring
// CORDIC rotation with a fixed shift.
// ----------------------------------------------------------------------------
module c2p_root_cell #(
   parameter int STEP   = 0,
   parameter bit ROTATE = 1'b1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  c2p_pkg::root_word_type in_word,
   output logic                   out_valid,
   output c2p_pkg::root_word_type out_word
);
   import c2p_pkg::*;

   localparam logic [WW-1:0] BIT_VAL = WW'(1) << (WW - 2 - 2 * STEP);

   logic                 valid_ff;
   root_word_type        word_ff, word_in;
   logic [WW-1:0]        trial;
   logic signed [WW-1:0] dx, dy;
   logic signed [ZW-1:0] ang;

   always_comb begin
      word_in = in_word;
      trial = in_word.root + BIT_VAL;
      dx = $signed(in_word.cx) >>> STEP;
      dy = $signed(in_word.cy) >>> STEP;
      ang = $signed({2'b00, ATAN_TAB[STEP]});
      // square root bit
      if (in_word.rad >= trial) begin
         word_in.rad  = in_word.rad - trial;
         word_in.root = (in_word.root >> 1) + BIT_VAL;
      end else begin
         word_in.root = in_word.root >> 1;
      end
      // rotate toward the x axis
      if (ROTATE) begin
         if (!in_word.cy[WW-1]) begin
            word_in.cx = in_word.cx + dy;
            word_in.cy = in_word.cy - dx;
            word_in.cz = in_word.cz + ang;
         end else begin
            word_in.cx = in_word.cx - dy;
            word_in.cy = in_word.cy + dx;
            word_in.cz = in_word.cz - ang;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

FILE: sv/c2p_div_cell.sv
// ----------------------------------------------------------------------------
// c2p_div_cell: one cell of the restoring divider chain
// Shifts in one dividend bit and settles one quotient bit.
// ----------------------------------------------------------------------------
module c2p_div_cell #(
   parameter int BIT = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  c2p_pkg::div_word_type in_word,
   output logic                  out_valid,
   output c2p_pkg::div_word_type out_word
);
   import c2p_pkg::*;

   logic          valid_ff;
   div_word_type  word_ff, word_in;
   logic [DW:0]   part;

   always_comb begin
      word_in = in_word;
      part = {in_word.rem[DW-1:0], in_word.dvd[BIT]};
      if (part >= {1'b0, in_word.dvs}) begin
         word_in.rem = part - {1'b0, in_word.dvs};
         word_in.quo[BIT] = 1'b1;
      end else begin
         word_in.rem = part;
         word_in.quo[BIT] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

FILE: sv/cartesian_to_polar_range_rate_unit.sv
// ----------------------------------------------------------------------------
// cartesian_to_polar_range_rate_unit: position/velocity to range, bearing and
// range rate
// Takes one word per clock while req_stall is low and returns one result
// word per input word, in order, through two input stages, 32 cells that
// each settle one bit of the square root while also doing one CORDIC
// rotation (CORDIC_STEPS of them rotate), a floor stage, 33 divider cells
// that each settle one quotient bit, a saturation stage and the output
// register. The chain of cells sets the latency; the rate is one word per
// cycle while no stall holds the chain. A skid register at the output lets
// the block take one more word while a result waits. min_range resets to 66
// (about 0.001 in Q16.16); a value of zero acts as one.
// ----------------------------------------------------------------------------
module cartesian_to_polar_range_rate_unit #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic               clock,
   input  logic               reset,
   // input words
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   // result words
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_range_out,
   output logic signed [31:0] rsp_bearing_out,
   output logic signed [31:0] rsp_range_rate_out,
   output logic               rsp_rate_saturated,
   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import c2p_pkg::*;

   logic [MRW-1:0] min_range_ff;
   logic           en;

   logic           rv [ROOT_CELLS+1];
   root_word_type  rw [ROOT_CELLS+1];
   logic           dv [DIV_CELLS+1];
   div_word_type   dw [DIV_CELLS+1];

   div_word_type   fl_in;
   logic           fl_valid_ff;
   div_word_type   fl_ff;
   logic [DW-1:0]  floor_v, root_v;
   logic signed [ZW-1:0] pi_z;

   logic           fin_valid_ff;
   result_type     fin_ff, fin_in;
   logic           rsp_valid_ff, skid_valid_ff;
   result_type     rsp_ff, skid_ff;
   logic           take;

   // register port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_MIN_RANGE) ? 32'(min_range_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_ff <= MIN_RANGE_RESET;
      end else if (psel && penable && pwrite && paddr[2] == REG_MIN_RANGE) begin
         min_range_ff <= pwdata[MRW-1:0];
      end
   end

   // whole chain moves unless the skid register is holding a word
   assign en = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   c2p_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .vel_x     (req_vel_x),
      .vel_y     (req_vel_y),
      .out_valid (rv[0]),
      .out_word  (rw[0])
   );

   // square root and CORDIC cells
   for (genvar g = 0; g < ROOT_CELLS; g++) begin : g_root
      c2p_root_cell #(
         .STEP   (g),
         .ROTATE (g < CORDIC_STEPS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (rv[g]),
         .in_word   (rw[g]),
         .out_valid (rv[g+1]),
         .out_word  (rw[g+1])
      );
   end

   // floor stage: clamp range and bearing, set up the divider
   always_comb begin
      pi_z = $signed({2'b00, PI_Q29});
      floor_v = (min_range_ff == '0) ? DW'(1) : DW'(min_range_ff);
      root_v = rw[ROOT_CELLS].root[DW-1:0];
      fl_in.rng = (root_v < floor_v) ? floor_v : root_v;
      fl_in.dvs = fl_in.rng;
      fl_in.dvd = rw[ROOT_CELLS].dot;
      fl_in.neg = rw[ROOT_CELLS].neg;
      fl_in.ovf = {1'b0, rw[ROOT_CELLS].dot[WW-1:DW+1]} >= fl_in.rng;
      fl_in.rem = {2'b00, rw[ROOT_CELLS].dot[WW-1:DW+1]};
      fl_in.quo = '0;
      if (rw[ROOT_CELLS].zero) begin
         fl_in.brg = '0;
      end else if ($signed(rw[ROOT_CELLS].cz) > pi_z) begin
         fl_in.brg = $signed(PI_Q29);
      end else if ($signed(rw[ROOT_CELLS].cz) < -pi_z) begin
         fl_in.brg = -$signed(PI_Q29);
      end else begin
         fl_in.brg = rw[ROOT_CELLS].cz[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fl_valid_ff <= 1'b0;
      end else if (en) begin
         fl_valid_ff <= rv[ROOT_CELLS];
      end
      if (en) begin
         fl_ff <= fl_in;
      end
   end

   assign dv[0] = fl_valid_ff;
   assign dw[0] = fl_ff;

   // divider cells, quotient bit 32 first
   for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
      c2p_div_cell #(
         .BIT (DIV_CELLS - 1 - g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dv[g]),
         .in_word   (dw[g]),
         .out_valid (dv[g+1]),
         .out_word  (dw[g+1])
      );
   end

   // saturate and apply the sign
   always_comb begin
      fin_in.rng = dw[DIV_CELLS].rng;
      fin_in.brg = dw[DIV_CELLS].brg;
      if (dw[DIV_CELLS].neg) begin
         fin_in.sat = dw[DIV_CELLS].ovf || (dw[DIV_CELLS].quo > {2'b01, {(DW-1){1'b0}}});
         fin_in.rate = fin_in.sat ? {1'b1, {(DW-1){1'b0}}}
                                  : DW'(-dw[DIV_CELLS].quo);
      end else begin
         fin_in.sat = dw[DIV_CELLS].ovf || (dw[DIV_CELLS].quo > {2'b00, {(DW-1){1'b1}}});
         fin_in.rate = fin_in.sat ? {1'b0, {(DW-1){1'b1}}}
                                  : dw[DIV_CELLS].quo[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (en) begin
         fin_valid_ff <= dv[DIV_CELLS];
      end
      if (en) begin
         fin_ff <= fin_in;
      end
   end

   // output register with skid
   assign take = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= fin_valid_ff;
         end
      end else if (fin_valid_ff && en) begin
         skid_valid_ff <= 1'b1;
      end
      if (take) begin
         rsp_ff <= skid_valid_ff ? skid_ff : fin_ff;
      end else if (en) begin
         skid_ff <= fin_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_range_out      = rsp_ff.rng;
   assign rsp_bearing_out    = rsp_ff.brg;
   assign rsp_range_rate_out = rsp_ff.rate;
   assign rsp_rate_saturated = rsp_ff.sat;

   // skid holds a word only behind a waiting output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word without an output word");

   // saturation flag only with a limit value
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.sat) |->
         (rsp_ff.rate == 32'sh7fffffff || rsp_ff.rate == 32'sh80000000))
      else $error("saturation flag with a non-limit range rate");

   // bearing stays within plus or minus pi
   a_bearing_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.brg <= $signed(PI_Q29) && rsp_ff.brg >= -$signed(PI_Q29)))
      else $error("bearing outside plus or minus pi");

   // a held output word does not move while the skid word waits
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && skid_valid_ff) |=> $stable(rsp_ff))
      else $error("output word changed while stalled with a skid word");

endmodule

FILE: bench/cartesian_to_polar_range_rate_unit_checker.sv
// ----------------------------------------------------------------------------
// Conversion checker
// Watches the input and result channels of the cartesian to polar unit,
// works out range, bearing and range rate for every accepted word and
// compares each accepted result word with the oldest pending prediction.
// ----------------------------------------------------------------------------
module cartesian_to_polar_range_rate_unit_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic signed [31:0]         req_pos_x,
   input  logic signed [31:0]         req_pos_y,
   input  logic signed [31:0]         req_vel_x,
   input  logic signed [31:0]         req_vel_y,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [31:0]                rsp_range_out,
   input  logic signed [31:0]         rsp_bearing_out,
   input  logic signed [31:0]         rsp_range_rate_out,
   input  logic                       rsp_rate_saturated,
   input  logic [c2p_pkg::MRW-1:0]    range_floor,
   output int                         fail_count,
   output int                         pending_count
);
   import c2p_pkg::*;

   result_type polar_queue[$];
   longint atan_q29 [32];
   longint pi_q29;

   // atan(1/n) in Q2.62 by the Gregory series
   function automatic longint unsigned atan_inv_q62(longint unsigned n);
      longint unsigned term, nsq, sum, k, t;
      term = (64'd1 << 62) / n;
      nsq  = n * n;
      sum  = 0;
      k    = 0;
      while (term != 0) begin
         t = term / (2 * k + 1);
         if (k[0]) sum = sum - t;
         else sum = sum + t;
         term = term / nsq;
         k++;
      end
      return sum;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint cordic_angle(longint px, longint py);
      longint x, y, z, dx, dy;
      x = px <<< PRE_SHIFT;
      y = py <<< PRE_SHIFT;
      z = 0;
      if (px == 0 && py == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? pi_q29 : -pi_q29;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 24; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y >= 0) begin
            x = x + dy; y = y - dx; z = z + atan_q29[i];
         end else begin
            x = x - dy; y = y + dx; z = z - atan_q29[i];
         end
      end
      if (z > pi_q29) z = pi_q29;
      if (z < -pi_q29) z = -pi_q29;
      return z;
   endfunction

   function automatic result_type polar_of(longint px, longint py, longint vx,
                                           longint vy);
      result_type r;
      longint unsigned flr, rng, m1, m2, dmag, q;
      longint p1, p2;
      logic neg, sat;
      flr = (range_floor == 0) ? 1 : 64'(range_floor);
      m1  = (px < 0) ? -px : px;
      m2  = (py < 0) ? -py : py;
      rng = int_sqrt(m1 * m1 + m2 * m2);
      if (rng < flr) rng = flr;
      p1 = px * vx;
      p2 = py * vy;
      m1 = (p1 < 0) ? -p1 : p1;
      m2 = (p2 < 0) ? -p2 : p2;
      if ((p1 < 0) == (p2 < 0)) begin
         dmag = m1 + m2; neg = p1 < 0;
      end else if (m1 >= m2) begin
         dmag = m1 - m2; neg = p1 < 0;
      end else begin
         dmag = m2 - m1; neg = p2 < 0;
      end
      if (dmag == 0) neg = 0;
      q   = dmag / rng;
      sat = 0;
      if (!neg && q > 64'h7fff_ffff) begin
         q = 64'h7fff_ffff; sat = 1;
      end else if (neg && q > 64'h8000_0000) begin
         q = 64'h8000_0000; sat = 1;
      end
      r.rng  = rng[31:0];
      r.brg  = 32'(cordic_angle(px, py));
      r.rate = neg ? 32'(-q) : 32'(q);
      r.sat  = sat;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   // arctangent table in Q3.29, rounded to nearest
   initial begin
      longint unsigned quarter;
      quarter = 4 * atan_inv_q62(5) - atan_inv_q62(239);
      atan_q29[0] = (quarter + (64'd1 << 32)) >> 33;
      for (int i = 1; i < 32; i++)
         atan_q29[i] = (atan_inv_q62(64'd1 << i) + (64'd1 << 32)) >> 33;
      pi_q29 = (4 * quarter + (64'd1 << 32)) >> 33;
      fail_count = 0;
   end

   assign pending_count = polar_queue.size();

   // predict on input words, compare on result words
   always @(posedge clock) begin
      result_type want;
      if (!reset && req_valid && !req_stall)
         polar_queue.push_back(polar_of(req_pos_x, req_pos_y, req_vel_x, req_vel_y));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (polar_queue.size() == 0) begin
            report_mismatch("result words pending", 1, 0);
         end else begin
            want = polar_queue.pop_front();
            if (rsp_range_out !== want.rng)
               report_mismatch("range", rsp_range_out, want.rng);
            if (rsp_bearing_out !== want.brg)
               report_mismatch("bearing", rsp_bearing_out, want.brg);
            if (rsp_range_rate_out !== want.rate)
               report_mismatch("range_rate", rsp_range_rate_out, want.rate);
            if (rsp_rate_saturated !== want.sat)
               report_mismatch("saturated", rsp_rate_saturated, want.sat);
         end
      end
   end

endmodule

FILE: bench/cartesian_to_polar_range_rate_unit_tb.sv
// ----------------------------------------------------------------------------
// Cartesian to polar unit testbench
// Drives directed corner words and random position/velocity words under
// several range floors and idle patterns; a checker module predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module cartesian_to_polar_range_rate_unit_tb;
   import c2p_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_pos_x, req_pos_y, req_vel_x, req_vel_y;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [31:0]        rsp_range_out;
   logic signed [31:0] rsp_bearing_out, rsp_range_rate_out;
   logic               rsp_rate_saturated;
   logic               psel, penable, pwrite;
   logic [2:0]         paddr;
   logic [31:0]        pwdata, prdata;
   logic               pready;
   logic [MRW-1:0]     range_floor;
   int                 fail_count, pending_count;
   int                 cycle_count;
   int                 rsp_idle_pct;

   cartesian_to_polar_range_rate_unit u_top (.*);

   cartesian_to_polar_range_rate_unit_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock)
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < rsp_idle_pct);

   task automatic write_floor(logic [MRW-1:0] value);
      @(negedge clock);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= {REG_MIN_RANGE, 2'b00}; pwdata <= value;
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      range_floor = value;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   task automatic send_word(logic [31:0] px, py, vx, vy, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_pos_x <= px; req_pos_y <= py; req_vel_x <= vx; req_vel_y <= vy;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain_pipe();
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
         default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      endcase
   endfunction

   initial begin
      logic [31:0] corner [6];
      logic [MRW-1:0] floors [6];
      int idle_in;
      corner = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                 32'h0001_0000};
      floors = '{17'd0, 17'd1, 17'h10000, 17'h1ffff, 17'd66, 17'($urandom)};
      reset = 1; req_valid = 0; rsp_idle_pct = 0;
      req_pos_x = 0; req_pos_y = 0; req_vel_x = 0; req_vel_y = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      range_floor = MIN_RANGE_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed corners: zero vector, axes, extremes, negative x on both sides
      for (int i = 0; i < 6; i++)
         for (int j = 0; j < 4; j++)
            send_word(corner[i], corner[(i + j) % 6], corner[(i + 2 * j) % 6],
                      corner[5 - i], 0);
      drain_pipe();

      // random phases across floors and idle patterns
      for (int phase = 0; phase < 6; phase++) begin
         write_floor(floors[phase]);
         idle_in      = (phase < 2) ? 9 : (phase < 4) ? 77 : 0;
         rsp_idle_pct = (phase < 2) ? 77 : (phase < 4) ? 9 : 0;
         for (int n = 0; n < 265; n++)
            send_word(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      idle_in);
         drain_pipe();
      end

      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

FILE: files.f
sv/c2p_pkg.sv
sv/c2p_front.sv
sv/c2p_root_cell.sv
sv/c2p_div_cell.sv
sv/cartesian_to_polar_range_rate_unit.sv
bench/cartesian_to_polar_range_rate_unit_checker.sv
bench/cartesian_to_polar_range_rate_unit_tb.sv
